// ----- sv/rmv_pkg.sv -----
// Shared types and constants for the running mean/variance block.
// No dependencies; imported by rmv_ram, rmv_div and the top level.
package rmv_pkg;

    localparam int MAX_COMPONENTS_DEF = 64;

    localparam int SAMPLE_W = 32;
    localparam int ACC_W    = 17;
    localparam int M2_W     = 48;
    localparam int ITER_W   = 32;
    localparam int LEN_W    = 7;
    localparam int IDX_O_W  = 6;
    localparam int VAR_W    = 31;

    // shared divider: 48-bit dividend, divisor up to 2^32
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 33;

    localparam logic [ACC_W-1:0]  ONE_Q16  = 17'd65536;
    localparam logic [M2_W-1:0]   M2_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam logic [VAR_W-1:0]  VAR_MAX  = 31'h7FFF_FFFF;
    localparam logic [ITER_W-1:0] ITER_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

endpackage

// ----- sv/running_mean_variance_vector.sv -----
// Running mean/variance (Welford) per vector component, top level.
// Depends on rmv_pkg, rmv_ram (mean and M2 stores) and rmv_div.
//
// Each request carries one component sample (signed Q16.16) and the
// acceptance probability (Q1.16, used on the last component). The block
// reads the component's mean and M2 from two RAMs, updates them and writes
// them back, then returns the new mean, variance M2/(n-1) (saturated,
// flagged invalid on the first iteration), the component index, the running
// acceptance average and an end-of-iteration flag. One request is handled
// at a time and the shared divider sets the pace: each division takes 48
// quotient steps plus the start and completion hand-off. Components of the
// first iteration but the last need the mean division only; every other
// component of later iterations and the last component of the first
// iteration need the mean plus a variance or acceptance division, and the
// last component of later iterations needs the mean, variance and
// acceptance divisions. Output back-pressure adds its own stall on top of
// these. After reset a clearing pass zeroes both stores, one entry per
// cycle; no request is taken meanwhile, though vector_length writes are.
// A result waiting at the output does not stop the next request from
// being taken and worked on.
module running_mean_variance_vector
    import rmv_pkg::*;
#(
    parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [LEN_W-1:0]           cfg_wdata,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [ACC_W-1:0]           accept_prob,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mean,
    output logic [VAR_W-1:0]           variance,
    output logic                       variance_valid,
    output logic [IDX_O_W-1:0]         component_index,
    output logic [ACC_W-1:0]           avg_accept_prob,
    output logic                       iteration_done
);

    localparam int IDX_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int CW    = ((IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W) + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_DIV_MEAN, S_MUL_LO, S_MUL_HI,
        S_WRITE, S_DIV_VAR, S_DIV_ACC, S_FINISH
    } state_t;

    state_t state_reg;

    // config and architectural state
    logic [LEN_W-1:0]  len_cfg_reg;
    logic [IDX_W-1:0]  position_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [ACC_W-1:0]  acc_avg_reg;
    logic [IDX_W-1:0]  clr_idx_reg;

    // per-request working registers
    logic [SAMPLE_W-1:0] sample_reg;
    logic [ACC_W-1:0]    acc_in_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                last_reg;
    logic [SAMPLE_W-1:0] mean_old_reg;
    logic [M2_W-1:0]     m2_reg;
    logic                dneg_reg;
    logic [SAMPLE_W:0]   dmag_reg;
    logic [SAMPLE_W-1:0] newmean_reg;
    logic [2*SAMPLE_W+1:0] prod_reg;
    logic [VAR_W-1:0]    var_reg;
    logic [ACC_W-1:0]    acc_new_reg;
    div_req_t            div_req_reg;

    // output register
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] mean_out_reg;
    logic [VAR_W-1:0]    var_out_reg;
    logic                var_valid_reg;
    logic [IDX_O_W-1:0]  idx_out_reg;
    logic [ACC_W-1:0]    avg_out_reg;
    logic                done_out_reg;

    // RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SAMPLE_W-1:0] mean_wdata;
    logic [M2_W-1:0]   m2_wdata;
    logic [SAMPLE_W-1:0] mean_rdata;
    logic [M2_W-1:0]   m2_rdata;

    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    // combinational helpers
    logic [CW-1:0]       len_eff;
    logic [CW-1:0]       len_raw;
    logic                last_now;
    logic [ACC_W-1:0]    acc_clamped;
    logic [SAMPLE_W:0]   delta;
    logic [SAMPLE_W:0]   dmag;
    logic [SAMPLE_W+1:0] qsigned;
    logic [SAMPLE_W+1:0] nm_wide;
    logic [SAMPLE_W:0]   diff2;
    logic [SAMPLE_W:0]   dmag2;
    logic [M2_W+1:0]     m2_sum;
    logic [M2_W-1:0]     m2_new;
    logic [ACC_W:0]      acc_diff;
    logic [ACC_W:0]      acc_mag;
    logic [ACC_W:0]      acc_q;
    logic [ACC_W:0]      acc_sum;
    logic [DIV_DEN_W-1:0] n_val;
    logic                load_out;

    // clamp the configured length into 1..MAX_COMPONENTS
    assign len_raw = CW'(len_cfg_reg);
    always_comb
    begin
        if (len_cfg_reg == '0)
        begin
            len_eff = CW'(1);
        end
        else if (len_raw > CW'(MAX_COMPONENTS))
        begin
            len_eff = CW'(MAX_COMPONENTS);
        end
        else
        begin
            len_eff = len_raw;
        end
    end
    assign last_now    = (CW'(position_reg) + CW'(1)) >= len_eff;
    assign acc_clamped = (accept_prob > ONE_Q16) ? ONE_Q16 : accept_prob;

    // n = completed iterations + 1
    assign n_val = {1'b0, iter_reg} + DIV_DEN_W'(1);

    // delta against the freshly read mean
    assign delta = {sample_reg[SAMPLE_W-1], sample_reg}
                 - {mean_rdata[SAMPLE_W-1], mean_rdata};
    assign dmag  = delta[SAMPLE_W] ? (~delta + 1'b1) : delta;

    // new mean = old mean + delta/n, truncated toward zero
    assign qsigned = dneg_reg ? (~{1'b0, div_quot[SAMPLE_W:0]} + 1'b1)
                              : {1'b0, div_quot[SAMPLE_W:0]};
    assign nm_wide = {{2{mean_old_reg[SAMPLE_W-1]}}, mean_old_reg} + qsigned;

    assign diff2 = {sample_reg[SAMPLE_W-1], sample_reg}
                 - {newmean_reg[SAMPLE_W-1], newmean_reg};
    assign dmag2 = diff2[SAMPLE_W] ? (~diff2 + 1'b1) : diff2;

    // M2 accumulate with saturation
    assign m2_sum = {2'b00, m2_reg} + prod_reg[2*SAMPLE_W+1:16];
    assign m2_new = (m2_sum > {2'b00, M2_MAX}) ? M2_MAX : m2_sum[M2_W-1:0];

    // acceptance average step
    assign acc_diff = {1'b0, acc_in_reg} - {1'b0, acc_avg_reg};
    assign acc_mag  = acc_diff[ACC_W] ? (~acc_diff + 1'b1) : acc_diff;
    assign acc_q    = acc_diff[ACC_W] ? (~div_quot[ACC_W:0] + 1'b1)
                                      : div_quot[ACC_W:0];
    assign acc_sum  = {1'b0, acc_avg_reg} + acc_q;

    assign ram_we     = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
    assign ram_waddr  = (state_reg == S_CLEAR) ? clr_idx_reg : idx_reg;
    assign mean_wdata = (state_reg == S_CLEAR) ? '0 : newmean_reg;
    assign m2_wdata   = (state_reg == S_CLEAR) ? '0 : m2_new;

    assign load_out = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    rmv_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_COMPONENTS)
    ) u_mean_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (mean_wdata),
        .raddr (position_reg),
        .rdata (mean_rdata)
    );

    rmv_ram #(
        .WIDTH (M2_W),
        .DEPTH (MAX_COMPONENTS)
    ) u_m2_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m2_wdata),
        .raddr (position_reg),
        .rdata (m2_rdata)
    );

    rmv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            len_cfg_reg   <= LEN_W'(1);
            position_reg  <= '0;
            iter_reg      <= '0;
            acc_avg_reg   <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            div_req_reg   <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            if (cfg_we)
            begin
                len_cfg_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IDX_W'(MAX_COMPONENTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample;
                        acc_in_reg <= acc_clamped;
                        idx_reg    <= position_reg;
                        last_reg   <= last_now;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    mean_old_reg      <= mean_rdata;
                    m2_reg            <= m2_rdata;
                    dneg_reg          <= delta[SAMPLE_W];
                    dmag_reg          <= dmag;
                    div_req_reg.start <= 1'b1;
                    div_req_reg.num   <= DIV_NUM_W'(dmag);
                    div_req_reg.den   <= n_val;
                    state_reg         <= S_DIV_MEAN;
                end
                S_DIV_MEAN:
                begin
                    if (div_done)
                    begin
                        newmean_reg <= nm_wide[SAMPLE_W-1:0];
                        state_reg   <= S_MUL_LO;
                    end
                end
                S_MUL_LO:
                begin
                    prod_reg  <= (2*SAMPLE_W+2)'(dmag_reg * dmag2[16:0]);
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    prod_reg  <= prod_reg
                               + ((2*SAMPLE_W+2)'(dmag_reg * dmag2[SAMPLE_W:17]) << 17);
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    var_reg <= '0;
                    if (iter_reg != '0)
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= m2_new;
                        div_req_reg.den   <= {1'b0, iter_reg};
                        state_reg         <= S_DIV_VAR;
                    end
                    else if (last_reg)
                    begin
                        div_req_reg.start <= 1'b1;
                        div_req_reg.num   <= DIV_NUM_W'(acc_mag);
                        div_req_reg.den   <= n_val;
                        state_reg         <= S_DIV_ACC;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_DIV_VAR:
                begin
                    if (div_done)
                    begin
                        var_reg <= (div_quot > DIV_NUM_W'(VAR_MAX))
                                 ? VAR_MAX : div_quot[VAR_W-1:0];
                        if (last_reg)
                        begin
                            div_req_reg.start <= 1'b1;
                            div_req_reg.num   <= DIV_NUM_W'(acc_mag);
                            div_req_reg.den   <= n_val;
                            state_reg         <= S_DIV_ACC;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_DIV_ACC:
                begin
                    if (div_done)
                    begin
                        acc_new_reg <= acc_sum[ACC_W-1:0];
                        state_reg   <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        mean_out_reg  <= newmean_reg;
                        var_out_reg   <= var_reg;
                        var_valid_reg <= (iter_reg != '0);
                        idx_out_reg   <= IDX_O_W'(idx_reg);
                        done_out_reg  <= last_reg;
                        if (last_reg)
                        begin
                            avg_out_reg  <= acc_new_reg;
                            acc_avg_reg  <= acc_new_reg;
                            position_reg <= '0;
                            if (iter_reg != ITER_MAX)
                            begin
                                iter_reg <= iter_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            avg_out_reg  <= acc_avg_reg;
                            position_reg <= idx_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign mean            = mean_out_reg;
    assign variance        = var_out_reg;
    assign variance_valid  = var_valid_reg;
    assign component_index = idx_out_reg;
    assign avg_accept_prob = avg_out_reg;
    assign iteration_done  = done_out_reg;

    // one request in flight at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in progress");

    // first-iteration results carry no variance
    a_var_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !variance_valid) |-> (variance == '0))
        else $error("variance nonzero while flagged invalid");

    // acceptance average never exceeds one
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (avg_accept_prob <= ONE_Q16))
        else $error("acceptance average out of range");

    // next position stays inside the stores
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(position_reg) < CW'(MAX_COMPONENTS)))
        else $error("component position out of range");

endmodule

// ----- sv/rmv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Uses rmv_pkg only for the WIDTH and DEPTH parameter defaults.
module rmv_ram
    import rmv_pkg::*;
#(
    parameter int WIDTH = SAMPLE_W,
    parameter int DEPTH = MAX_COMPONENTS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/rmv_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rmv_pkg (div_req_t, operand widths).
module rmv_div
    import rmv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   trial;

    assign rem_sh = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign trial  = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            den_reg <= req.den;
            quo_reg <= req.num;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_DEN_W])
            begin
                rem_reg <= trial[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
